>>> sv/ptc_pkg.sv
// Shared constants, types and divider step for the pressure/temperature compensation block.
package ptc_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgTempCalib     = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgPressCalibLow  = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgPressCalibHigh = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgPressCalibLast = 4'd3;

  localparam int CfgDataW = 64;

  // Formula constants
  localparam logic signed [24:0] FineOffset = 25'sd128000;
  localparam logic [20:0]        PressBase  = 21'd1048576;
  localparam logic [11:0]        NumScale   = 12'd3125;
  localparam logic [63:0]        PressBias  = 64'h0000_8000_0000_0000;

  // Divider: quotient bits per pipeline stage
  localparam int DivBits   = 2;
  localparam int DivStages = 64 / DivBits;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] nq;   // numerator bits shift out the top, quotient bits in at the bottom
  } div_t;

  function automatic div_t div_step(div_t s, logic [30:0] md);
    div_t        r;
    logic [31:0] t;
    r = s;
    for (int i = 0; i < DivBits; i++) begin
      t    = {r.rem, r.nq[63]};
      r.nq = {r.nq[62:0], 1'b0};
      if (t >= {1'b0, md}) begin
        t       = t - {1'b0, md};
        r.nq[0] = 1'b1;
      end
      r.rem = t[30:0];
    end
    return r;
  endfunction

endpackage

>>> sv/pressure_temp_compensation.sv
// Pressure/temperature compensation: fully pipelined datapath with a pipelined divider.
//
// Each transfer on the input carries a raw 20-bit temperature and pressure
// conversion; one result comes out per item, in order. The path is 49 register
// stages deep: ten stages of temperature and pressure-coefficient math, the
// radix-4 restoring divider (a sign/magnitude entry stage plus 32 stages of two
// quotient bits each) and six stages of correction terms and output register.
// One item is accepted every cycle while the output is not stalled. A stalled
// output freezes the whole pipeline, so input stall follows output stall in
// that cycle. Calibration words are held in four write-only registers that are
// read directly by the stages that use them; write them only while no item is
// in flight.
module pressure_temp_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [19:0]                   temp_reading_i,
  input  logic [19:0]                   press_reading_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            temperature_centi_o,
  output logic signed [31:0]            fine_temperature_o,
  output logic [31:0]                   pressure_q24_8_o,
  output logic                          divisor_zero_o
);

  localparam int NDiv = ptc_pkg::DivStages;

  // ---------------- configuration ----------------
  logic [47:0] temp_calib_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [15:0] press_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_lo_q   <= '0;
      press_hi_q   <= '0;
      press_last_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ptc_pkg::CfgTempCalib:      temp_calib_q <= cfg_data_i[47:0];
        ptc_pkg::CfgPressCalibLow:  press_lo_q   <= cfg_data_i;
        ptc_pkg::CfgPressCalibHigh: press_hi_q   <= cfg_data_i;
        ptc_pkg::CfgPressCalibLast: press_last_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_calib_q[15:0];
  assign t2 = $signed(temp_calib_q[31:16]);
  assign t3 = $signed(temp_calib_q[47:32]);
  assign p1 = press_lo_q[15:0];
  assign p2 = $signed(press_lo_q[31:16]);
  assign p3 = $signed(press_lo_q[47:32]);
  assign p4 = $signed(press_lo_q[63:48]);
  assign p5 = $signed(press_hi_q[15:0]);
  assign p6 = $signed(press_hi_q[31:16]);
  assign p7 = $signed(press_hi_q[47:32]);
  assign p8 = $signed(press_hi_q[63:48]);
  assign p9 = $signed(press_last_q);

  // ---------------- flow control ----------------
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic [10:1] sv_q;  // valid bits of stages 1..10
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[9:1], in_valid_i};
    end
  end

  // ---------------- stage 1: temperature products ----------------
  logic signed [17:0] x_s1;
  logic signed [16:0] d_s1;
  logic signed [33:0] xt2_s1, dd_s1;
  assign x_s1   = $signed({1'b0, temp_reading_i[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d_s1   = $signed({1'b0, temp_reading_i[19:4]}) - $signed({1'b0, t1});
  assign xt2_s1 = x_s1 * t2;
  assign dd_s1  = d_s1 * d_s1;

  logic signed [33:0] s1_xt2_q;
  logic [31:0]        s1_dd_q;
  logic [20:0]        s1_pn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_xt2_q <= xt2_s1;
      s1_dd_q  <= dd_s1[31:0];
      s1_pn_q  <= ptc_pkg::PressBase - {1'b0, press_reading_i};
    end
  end

  // ---------------- stage 2 ----------------
  logic signed [36:0] b1_s2;
  assign b1_s2 = $signed({1'b0, s1_dd_q[31:12]}) * t3;

  logic signed [22:0] s2_at_q;
  logic signed [36:0] s2_b1_q;
  logic [20:0]        s2_pn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_at_q <= s1_xt2_q[33:11];
      s2_b1_q <= b1_s2;
      s2_pn_q <= s1_pn_q;
    end
  end

  // ---------------- stage 3: fine temperature ----------------
  logic signed [23:0] s3_fine_q;
  logic [20:0]        s3_pn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_fine_q <= {s2_at_q[22], s2_at_q} + {s2_b1_q[36], s2_b1_q[36:14]};
      s3_pn_q   <= s2_pn_q;
    end
  end

  // ---------------- stage 4: offset, square, centidegrees ----------------
  logic signed [24:0] pa_s4;
  logic signed [49:0] paa_s4;
  logic signed [26:0] c5_s4;
  assign pa_s4  = {s3_fine_q[23], s3_fine_q} - ptc_pkg::FineOffset;
  assign paa_s4 = pa_s4 * pa_s4;
  assign c5_s4  = $signed({{3{s3_fine_q[23]}}, s3_fine_q}) * 27'sd5 + 27'sd128;

  logic signed [24:0] s4_pa_q;
  logic [46:0]        s4_paa_q;
  logic signed [23:0] s4_fine_q;
  logic signed [18:0] s4_cent_q;
  logic [20:0]        s4_pn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pa_q   <= pa_s4;
      s4_paa_q  <= paa_s4[46:0];
      s4_fine_q <= s3_fine_q;
      s4_cent_q <= c5_s4[26:8];
      s4_pn_q   <= s3_pn_q;
    end
  end

  // ---------------- stage 5: coefficient products ----------------
  logic signed [48:0] m6l_s5, m3l_s5;
  logic signed [31:0] m6h_s5, m3h_s5;
  logic signed [40:0] m5_s5, m2_s5;
  assign m6l_s5 = $signed({1'b0, s4_paa_q[31:0]}) * p6;
  assign m6h_s5 = $signed({1'b0, s4_paa_q[46:32]}) * p6;
  assign m3l_s5 = $signed({1'b0, s4_paa_q[31:0]}) * p3;
  assign m3h_s5 = $signed({1'b0, s4_paa_q[46:32]}) * p3;
  assign m5_s5  = s4_pa_q * p5;
  assign m2_s5  = s4_pa_q * p2;

  logic signed [48:0] s5_m6l_q, s5_m3l_q;
  logic signed [31:0] s5_m6h_q, s5_m3h_q;
  logic signed [40:0] s5_m5_q, s5_m2_q;
  logic signed [23:0] s5_fine_q;
  logic signed [18:0] s5_cent_q;
  logic [20:0]        s5_pn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_m6l_q  <= m6l_s5;
      s5_m6h_q  <= m6h_s5;
      s5_m3l_q  <= m3l_s5;
      s5_m3h_q  <= m3h_s5;
      s5_m5_q   <= m5_s5;
      s5_m2_q   <= m2_s5;
      s5_fine_q <= s4_fine_q;
      s5_cent_q <= s4_cent_q;
      s5_pn_q   <= s4_pn_q;
    end
  end

  // ---------------- stage 6: combine partial products ----------------
  logic [63:0]        s6_b6_q, s6_a3_q;
  logic signed [40:0] s6_m5_q, s6_m2_q;
  logic signed [23:0] s6_fine_q;
  logic signed [18:0] s6_cent_q;
  logic [20:0]        s6_pn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_b6_q   <= {{15{s5_m6l_q[48]}}, s5_m6l_q} + {s5_m6h_q, 32'b0};
      s6_a3_q   <= {{15{s5_m3l_q[48]}}, s5_m3l_q} + {s5_m3h_q, 32'b0};
      s6_m5_q   <= s5_m5_q;
      s6_m2_q   <= s5_m2_q;
      s6_fine_q <= s5_fine_q;
      s6_cent_q <= s5_cent_q;
      s6_pn_q   <= s5_pn_q;
    end
  end

  // ---------------- stage 7: numerator offset and divisor base ----------------
  logic [63:0]        s7_b_q, s7_s_q;
  logic signed [23:0] s7_fine_q;
  logic signed [18:0] s7_cent_q;
  logic [20:0]        s7_pn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_b_q    <= s6_b6_q + {{6{s6_m5_q[40]}}, s6_m5_q, 17'b0}
                   + {{13{p4[15]}}, p4, 35'b0};
      s7_s_q    <= ptc_pkg::PressBias + {{8{s6_a3_q[63]}}, s6_a3_q[63:8]}
                   + {{11{s6_m2_q[40]}}, s6_m2_q, 12'b0};
      s7_fine_q <= s6_fine_q;
      s7_cent_q <= s6_cent_q;
      s7_pn_q   <= s6_pn_q;
    end
  end

  // ---------------- stage 8: divisor products, numerator difference ----------------
  logic [47:0] sp1l_s8, sp1h_s8;
  assign sp1l_s8 = s7_s_q[31:0] * p1;
  assign sp1h_s8 = s7_s_q[63:32] * p1;

  logic [47:0]        s8_sp1l_q;
  logic [31:0]        s8_sp1h_q;
  logic [63:0]        s8_n0_q;
  logic signed [23:0] s8_fine_q;
  logic signed [18:0] s8_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_sp1l_q <= sp1l_s8;
      s8_sp1h_q <= sp1h_s8[31:0];
      s8_n0_q   <= {12'b0, s7_pn_q, 31'b0} - s7_b_q;
      s8_fine_q <= s7_fine_q;
      s8_cent_q <= s7_cent_q;
    end
  end

  // ---------------- stage 9: divisor, numerator scale products ----------------
  logic [63:0] dv64_s9;
  logic [43:0] nl_s9, nh_s9;
  assign dv64_s9 = {16'b0, s8_sp1l_q} + {s8_sp1h_q, 32'b0};
  assign nl_s9   = s8_n0_q[31:0] * ptc_pkg::NumScale;
  assign nh_s9   = s8_n0_q[63:32] * ptc_pkg::NumScale;

  logic signed [30:0] s9_dvs_q;
  logic [43:0]        s9_nl_q;
  logic [31:0]        s9_nh_q;
  logic signed [23:0] s9_fine_q;
  logic signed [18:0] s9_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_dvs_q  <= $signed(dv64_s9[63:33]);
      s9_nl_q   <= nl_s9;
      s9_nh_q   <= nh_s9[31:0];
      s9_fine_q <= s8_fine_q;
      s9_cent_q <= s8_cent_q;
    end
  end

  // ---------------- stage 10: numerator ----------------
  logic [63:0]        s10_num_q;
  logic signed [30:0] s10_dvs_q;
  logic signed [23:0] s10_fine_q;
  logic signed [18:0] s10_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_num_q  <= {20'b0, s9_nl_q} + {s9_nh_q, 32'b0};
      s10_dvs_q  <= s9_dvs_q;
      s10_fine_q <= s9_fine_q;
      s10_cent_q <= s9_cent_q;
    end
  end

  // ---------------- divider pipeline ----------------
  // Entry 0 takes magnitudes and signs; each following entry resolves DivBits quotient bits.
  logic [NDiv:0]          dv_valid_q;
  ptc_pkg::div_t          dv_st_q   [NDiv+1];
  logic [30:0]            dv_md_q   [NDiv+1];
  logic                   dv_qneg_q [NDiv+1];
  logic                   dv_zero_q [NDiv+1];
  logic signed [23:0]     dv_fine_q [NDiv+1];
  logic signed [18:0]     dv_cent_q [NDiv+1];

  logic [63:0] mn_d;
  logic [30:0] md_d;
  assign mn_d = s10_num_q[63] ? (64'd0 - s10_num_q) : s10_num_q;
  assign md_d = s10_dvs_q[30] ? (31'd0 - s10_dvs_q) : s10_dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q <= '0;
    end else if (en) begin
      dv_valid_q <= {dv_valid_q[NDiv-1:0], sv_q[10]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_st_q[0]   <= '{rem: '0, nq: mn_d};
      dv_md_q[0]   <= md_d;
      dv_qneg_q[0] <= s10_num_q[63] ^ s10_dvs_q[30];
      dv_zero_q[0] <= (s10_dvs_q == '0);
      dv_fine_q[0] <= s10_fine_q;
      dv_cent_q[0] <= s10_cent_q;
      for (int k = 0; k < NDiv; k++) begin
        dv_st_q[k+1]   <= ptc_pkg::div_step(dv_st_q[k], dv_md_q[k]);
        dv_md_q[k+1]   <= dv_md_q[k];
        dv_qneg_q[k+1] <= dv_qneg_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
        dv_fine_q[k+1] <= dv_fine_q[k];
        dv_cent_q[k+1] <= dv_cent_q[k];
      end
    end
  end

  // ---------------- post stages ----------------
  logic [5:1] pv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[4:1], dv_valid_q[NDiv]};
    end
  end

  // P1: signed quotient
  logic [63:0]        p1_q_q;
  logic               p1_zero_q;
  logic signed [23:0] p1_fine_q;
  logic signed [18:0] p1_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q_q    <= dv_qneg_q[NDiv] ? (64'd0 - dv_st_q[NDiv].nq) : dv_st_q[NDiv].nq;
      p1_zero_q <= dv_zero_q[NDiv];
      p1_fine_q <= dv_fine_q[NDiv];
      p1_cent_q <= dv_cent_q[NDiv];
    end
  end

  // P2: square and P8 products
  logic [63:0]        qs_p2;
  logic [63:0]        ll_p2, lh_p2;
  logic signed [48:0] el_p2;
  logic signed [47:0] eh_p2;
  assign qs_p2 = {{13{p1_q_q[63]}}, p1_q_q[63:13]};
  assign ll_p2 = qs_p2[31:0] * qs_p2[31:0];
  assign lh_p2 = qs_p2[31:0] * qs_p2[63:32];
  assign el_p2 = $signed({1'b0, p1_q_q[31:0]}) * p8;
  assign eh_p2 = $signed(p1_q_q[63:32]) * p8;

  logic [63:0]        p2_ll_q, p2_q_q;
  logic [30:0]        p2_lh_q;
  logic signed [48:0] p2_el_q;
  logic [31:0]        p2_eh_q;
  logic               p2_zero_q;
  logic signed [23:0] p2_fine_q;
  logic signed [18:0] p2_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_ll_q   <= ll_p2;
      p2_lh_q   <= lh_p2[30:0];
      p2_el_q   <= el_p2;
      p2_eh_q   <= eh_p2[31:0];
      p2_q_q    <= p1_q_q;
      p2_zero_q <= p1_zero_q;
      p2_fine_q <= p1_fine_q;
      p2_cent_q <= p1_cent_q;
    end
  end

  // P3: square sum, P8 term
  logic [63:0] ef_p3;
  assign ef_p3 = {{15{p2_el_q[48]}}, p2_el_q} + {p2_eh_q, 32'b0};

  logic [63:0]        p3_sq_q, p3_e_q, p3_q_q;
  logic               p3_zero_q;
  logic signed [23:0] p3_fine_q;
  logic signed [18:0] p3_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_sq_q   <= p2_ll_q + {p2_lh_q, 33'b0};
      p3_e_q    <= {{19{ef_p3[63]}}, ef_p3[63:19]};
      p3_q_q    <= p2_q_q;
      p3_zero_q <= p2_zero_q;
      p3_fine_q <= p2_fine_q;
      p3_cent_q <= p2_cent_q;
    end
  end

  // P4: P9 products
  logic signed [48:0] cl_p4;
  logic signed [47:0] ch_p4;
  assign cl_p4 = $signed({1'b0, p3_sq_q[31:0]}) * p9;
  assign ch_p4 = $signed(p3_sq_q[63:32]) * p9;

  logic signed [48:0] p4_cl_q;
  logic [31:0]        p4_ch_q;
  logic [63:0]        p4_e_q, p4_q_q;
  logic               p4_zero_q;
  logic signed [23:0] p4_fine_q;
  logic signed [18:0] p4_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_cl_q   <= cl_p4;
      p4_ch_q   <= ch_p4[31:0];
      p4_e_q    <= p3_e_q;
      p4_q_q    <= p3_q_q;
      p4_zero_q <= p3_zero_q;
      p4_fine_q <= p3_fine_q;
      p4_cent_q <= p3_cent_q;
    end
  end

  // P5: P9 term
  logic [63:0] cf_p5;
  assign cf_p5 = {{15{p4_cl_q[48]}}, p4_cl_q} + {p4_ch_q, 32'b0};

  logic [39:0]        p5_c_q, p5_e_q, p5_q_q;
  logic               p5_zero_q;
  logic signed [23:0] p5_fine_q;
  logic signed [18:0] p5_cent_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      // low 40 bits of the arithmetic shift right by 25
      p5_c_q    <= {cf_p5[63], cf_p5[63:25]};
      p5_e_q    <= p4_e_q[39:0];
      p5_q_q    <= p4_q_q[39:0];
      p5_zero_q <= p4_zero_q;
      p5_fine_q <= p4_fine_q;
      p5_cent_q <= p4_cent_q;
    end
  end

  // P6: output register
  logic [39:0]        sum_p6;
  logic [31:0]        pres_p6;
  assign sum_p6  = p5_q_q + p5_c_q + p5_e_q;
  assign pres_p6 = sum_p6[39:8] + {{12{p7[15]}}, p7, 4'b0};

  logic [31:0]        out_pres_q;
  logic               out_zero_q;
  logic signed [23:0] out_fine_q;
  logic signed [18:0] out_cent_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pv_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pres_q <= p5_zero_q ? '0 : pres_p6;
      out_zero_q <= p5_zero_q;
      out_fine_q <= p5_fine_q;
      out_cent_q <= p5_cent_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pressure_q24_8_o    = out_pres_q;
  assign divisor_zero_o      = out_zero_q;
  assign fine_temperature_o  = {{8{out_fine_q[23]}}, out_fine_q};
  assign temperature_centi_o = {{13{out_cent_q[18]}}, out_cent_q};

endmodule

>>> bench/pressure_temp_compensation_tb.sv
// Testbench for the pressure/temperature compensation block: directed table plus random traffic.
`timescale 1ns / 1ps
module pressure_temp_compensation_tb;

  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic [31:0]        press;
    logic               dzero;
  } comp_t;

  typedef struct {
    logic [19:0] temp_code;
    logic [19:0] press_code;
    logic        known;
    comp_t       res;
  } row_t;

  // index with no register behind it
  localparam logic [ptc_pkg::CfgIdxW-1:0] CfgIdxUnused = 4'd9;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ptc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [ptc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [19:0] temp_reading_i = '0;
  logic [19:0] press_reading_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] temperature_centi_o, fine_temperature_o;
  logic [31:0] pressure_q24_8_o;
  logic divisor_zero_o;

  pressure_temp_compensation DUT (.*);

  always #5 clk_i = ~clk_i;

  // calibration copy
  logic [47:0] cal_t;
  logic [63:0] cal_pl, cal_ph;
  logic [15:0] cal_p9;

  comp_t expected_q[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    hold_rx = 1'b0;
  bit    stim_done = 1'b0;

  function automatic logic signed [63:0] s16(logic [63:0] v, int pos);
    logic [15:0] w;
    w = v[pos +: 16];
    return {{48{w[15]}}, w};
  endfunction

  function automatic comp_t compensate(logic [19:0] tr, logic [19:0] pr);
    comp_t r;
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, b, d, fine, p, c, e, num;
    logic [63:0] mn, md, q;
    t1 = {48'd0, cal_t[15:0]};
    t2 = s16(cal_t, 16);
    t3 = s16(cal_t, 32);
    p1 = {48'd0, cal_pl[15:0]};
    p2 = s16(cal_pl, 16);
    p3 = s16(cal_pl, 32);
    p4 = s16(cal_pl, 48);
    p5 = s16(cal_ph, 0);
    p6 = s16(cal_ph, 16);
    p7 = s16(cal_ph, 32);
    p8 = s16(cal_ph, 48);
    p9 = s16({48'd0, cal_p9}, 0);
    a = ((64'(tr) >>> 3) - (t1 <<< 1)) * t2;
    a = a >>> 11;
    d = (64'(tr) >>> 4) - t1;
    b = ((d * d) >>> 12) * t3;
    b = b >>> 14;
    fine = {{32{a[31] ^ 1'b0}}, 32'd0};
    fine = a + b;
    fine = {{32{fine[31]}}, fine[31:0]};
    r.fine = fine[31:0];
    a = (fine * 5 + 128) >>> 8;
    r.centi = a[31:0];
    a = fine - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.dzero = 1'b1;
      r.press = '0;
    end else begin
      p = 64'sd1048576 - 64'(pr);
      num = ((p <<< 31) - b) * 64'sd3125;
      mn = num[63] ? -num : num;
      md = a[63] ? -a : a;
      q = mn / md;
      p = (num[63] != a[63]) ? -q : q;
      c = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      e = (p8 * p) >>> 19;
      p = ((p + c + e) >>> 8) + (p7 <<< 4);
      r.dzero = 1'b0;
      r.press = p[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(logic [ptc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ptc_pkg::CfgTempCalib: cal_t = val[47:0];
      ptc_pkg::CfgPressCalibLow: cal_pl = val;
      ptc_pkg::CfgPressCalibHigh: cal_ph = val;
      ptc_pkg::CfgPressCalibLast: cal_p9 = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // one item: random gap, offer, wait for the transfer
  task automatic send_item(logic [19:0] tr, logic [19:0] pr, bit known, comp_t res);
    comp_t pred;
    int    gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    temp_reading_i <= tr;
    press_reading_i <= pr;
    pred = compensate(tr, pr);
    if (known && pred != res) begin
      $error("table row mismatch: raw %0d/%0d", tr, pr);
      errors++;
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(known ? res : pred);
  endtask

  task automatic set_calib(logic [47:0] t, logic [63:0] pl, logic [63:0] ph, logic [15:0] p9);
    write_reg(ptc_pkg::CfgTempCalib, {16'hFFFF, t});
    write_reg(ptc_pkg::CfgPressCalibLow, pl);
    write_reg(ptc_pkg::CfgPressCalibHigh, ph);
    write_reg(ptc_pkg::CfgPressCalibLast, {48'hFFFF_FFFF_FFFF, p9});
    write_reg(CfgIdxUnused, 64'($urandom()));  // must be ignored
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // typical sensor calibration
  localparam logic [47:0] TypT = {16'sd50, 16'sd26435, 16'd27504};
  localparam logic [63:0] TypPL = {16'sd2855, 16'sd8192, -16'sd10685, 16'd36477};
  localparam logic [63:0] TypPH = {-16'sd7000, 16'sd15500, -16'sd7, 16'sd140};

  row_t dir_rows[$];

  function automatic row_t row(logic [19:0] t, logic [19:0] p, bit k, comp_t r);
    row_t x;
    x.temp_code = t; x.press_code = p; x.known = k; x.res = r;
    return x;
  endfunction

  initial begin
    comp_t zr, nr;
    int n;
    cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0;
    zr.centi = 0; zr.fine = 0; zr.press = 0; zr.dzero = 1'b1;
    nr = zr;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // after reset all coefficients are zero: fine is zero and the divisor is zero
    dir_rows.push_back(row(20'd0, 20'd0, 1, zr));
    dir_rows.push_back(row(20'hFFFFF, 20'hFFFFF, 1, zr));
    dir_rows.push_back(row(20'h55555, 20'hAAAAA, 1, zr));
    foreach (dir_rows[i])
      send_item(dir_rows[i].temp_code, dir_rows[i].press_code, 1, dir_rows[i].res);
    drain();
    // typical calibration, field extremes
    set_calib(TypT, TypPL, TypPH, 16'sd6000);
    dir_rows.delete();
    dir_rows.push_back(row(20'd0, 20'd0, 0, nr));
    dir_rows.push_back(row(20'hFFFFF, 20'hFFFFF, 0, nr));
    dir_rows.push_back(row(20'd519888, 20'd415148, 0, nr));
    dir_rows.push_back(row(20'd0, 20'hFFFFF, 0, nr));
    dir_rows.push_back(row(20'hFFFFF, 20'd0, 0, nr));
    dir_rows.push_back(row(20'hAAAAA, 20'h55555, 0, nr));
    foreach (dir_rows[i]) send_item(dir_rows[i].temp_code, dir_rows[i].press_code, 0, nr);
    drain();
    // extreme coefficients
    set_calib(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
    for (int i = 0; i < 4; i++)
      send_item(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0, 0, nr);
    drain();
    set_calib(48'h8000_8000_0000, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000, 16'h8000);
    for (int i = 0; i < 4; i++)
      send_item(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0, 0, nr);
    // long receiver hold while the sender keeps offering
    hold_rx = 1'b1;
    for (int i = 0; i < 80; i++) send_item(20'($urandom()), 20'($urandom()), 0, nr);
    drain();
    // random phases; sender pauses for a full drain at each phase boundary
    n = 0;
    while (n < 1800) begin
      case ($urandom_range(0, 3))
        0: set_calib(TypT ^ ($urandom() & 48'h00FF_00FF_0FFF),
                     TypPL ^ ($urandom() & 32'h00FF_0FFF), TypPH, 16'($urandom()));
        1: set_calib(48'(rnd64()), rnd64(), rnd64(), 16'($urandom()));
        2: set_calib(TypT, {rnd64() & 64'hFFFF_FFFF_FFFF_0000}, rnd64(), 16'($urandom()));
        default: set_calib(TypT, TypPL, TypPH, 16'sd6000);
      endcase
      for (int i = 0; i < 150; i++) begin
        send_item(20'($urandom()), 20'($urandom()), 0, nr);
        n++;
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // receiver: random wait before each result, plus one long hold
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_rx = 1'b0;
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        // a result was taken at this edge: draw the wait for the next one
        w = $urandom_range(0, 9);
        if (w != 0) begin
          out_stall_i <= 1'b1;
          repeat (w) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // checker and watchdog
  always @(posedge clk_i) begin
    comp_t x;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          x = expected_q.pop_front();
          if (temperature_centi_o !== x.centi) begin
            $error("temperature_centi exp %0d got %0d", x.centi, temperature_centi_o);
            errors++;
          end
          if (fine_temperature_o !== x.fine) begin
            $error("fine_temperature exp %0d got %0d", x.fine, fine_temperature_o);
            errors++;
          end
          if (pressure_q24_8_o !== x.press) begin
            $error("pressure_q24_8 exp %0h got %0h", x.press, pressure_q24_8_o);
            errors++;
          end
          if (divisor_zero_o !== x.dzero) begin
            $error("divisor_zero exp %0b got %0b", x.dzero, divisor_zero_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> pressure_temp_compensation.f
sv/ptc_pkg.sv
sv/pressure_temp_compensation.sv
bench/pressure_temp_compensation_tb.sv
